// File: hw/rtl/are_pkg.sv
// are_pkg: shared types, constants and codes of the ack/retransmit engine
// no dependencies
`default_nettype none
package are_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // input commands
   localparam logic [1:0] CMD_RECEIVE = 2'd0;
   localparam logic [1:0] CMD_SEND    = 2'd1;
   localparam logic [1:0] CMD_CHECK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_DELIVER    = 3'd0;
   localparam logic [2:0] KIND_ACK        = 3'd1;
   localparam logic [2:0] KIND_TRANSMIT   = 3'd2;
   localparam logic [2:0] KIND_RETRANSMIT = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW   = 3'd4;

   // register indexes
   localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_MAX_RETRY   = 2'd1;
   localparam logic [1:0] REG_RUNNING     = 2'd2;
   localparam logic [1:0] REG_ACK_TYPE    = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        seq;
      logic [7:0]         msg_type;
      logic signed [31:0] position;
      logic signed [31:0] payload_a;
      logic signed [31:0] payload_b;
      logic [31:0]        now_ms;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        out_seq;
      logic [7:0]         out_type;
      logic signed [31:0] out_position;
      logic signed [31:0] out_payload_a;
      logic signed [31:0] out_payload_b;
      logic               last;
   } rsp_item_type;

   // control from the sequencer to the output stage
   typedef struct packed {
      logic push;
      logic flush;
   } emit_ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/are_emit.sv
// are_emit: holds back one result so the final one of an item can carry last
// depends on are_pkg
`default_nettype none
module are_emit (
   input  wire                   clock,
   input  wire                   reset,
   input  are_pkg::emit_ctrl_type ctrl,
   input  are_pkg::rsp_item_type  new_item,
   output logic                  rsp_valid,
   output are_pkg::rsp_item_type  rsp_data
);
   import are_pkg::*;

   logic         hold_valid_ff, hold_valid_in;
   rsp_item_type hold_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;

   // a new item pushes out the held one; flush sends the held one as last
   always_comb begin
      hold_valid_in = hold_valid_ff;
      out_valid_in  = 1'b0;
      out_in        = hold_ff;
      out_in.last   = 1'b0;
      if (ctrl.push) begin
         out_valid_in  = hold_valid_ff;
         hold_valid_in = 1'b1;
      end else if (ctrl.flush) begin
         out_valid_in  = hold_valid_ff;
         out_in.last   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      if (ctrl.push) begin
         hold_ff <= new_item;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

// File: hw/rtl/ack_retransmit_engine.sv
// ack_retransmit_engine: pending-table sequencer with one shared compare unit
// depends on are_pkg and are_emit
// a receive runs RECV, ACKS, FLUSH; a send walks the table, STORE (OVF when full), FLUSH;
//   a running check walks the table, FLUSH; an ack item walks the table with no result
// throughput: one item at a time; busy drops in the cycle that shows the final result
// results come one per cycle at most and cannot be stalled
// reset (synchronous): registers to defaults, table empty, nothing received yet
`default_nettype none
module ack_retransmit_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  are_pkg::req_item_type  req_data,
   output logic                  rsp_valid,
   output are_pkg::rsp_item_type  rsp_data,
   input  wire                   csr_we,
   input  wire  [1:0]            csr_addr,
   input  wire  [15:0]           csr_wdata
);
   import are_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RECV  = 3'd1;
   localparam logic [2:0] ST_ACKS  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_STORE = 3'd4;
   localparam logic [2:0] ST_OVF   = 3'd5;
   localparam logic [2:0] ST_FLUSH = 3'd6;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // configuration
   logic [15:0] timeout_ff;
   logic [7:0]  max_retry_ff;
   logic        running_ff;
   logic [7:0]  ack_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= 16'd500;
         max_retry_ff <= 8'd3;
         running_ff   <= 1'b1;
         ack_code_ff  <= 8'd0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ACK_TIMEOUT: timeout_ff   <= csr_wdata;
            REG_MAX_RETRY:   max_retry_ff <= csr_wdata[7:0];
            REG_RUNNING:     running_ff   <= csr_wdata[0];
            REG_ACK_TYPE:    ack_code_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // pending table
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]        t_seq   [TABLE_DEPTH];
   logic [7:0]         t_type  [TABLE_DEPTH];
   logic signed [31:0] t_pos   [TABLE_DEPTH];
   logic signed [31:0] t_pa    [TABLE_DEPTH];
   logic signed [31:0] t_pb    [TABLE_DEPTH];
   logic [31:0]        t_time  [TABLE_DEPTH];
   logic [7:0]         t_retry [TABLE_DEPTH];

   // sequencer state
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   req_item_type     item_ff;
   logic             exp_valid_ff, exp_valid_in;
   logic [31:0]      exp_seq_ff, exp_seq_in;
   logic             hit_ff, hit_in, free_ff, free_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;

   // table writes decided by the sequencer
   logic             wr_full;
   logic             wr_retry;
   logic [IDX_W-1:0] wr_idx;

   emit_ctrl_type ctrl;
   rsp_item_type  new_item;

   // shared compare unit: key match and age check on the entry under the walk
   logic [31:0] key;
   logic        seq_match;
   logic [31:0] age;
   logic        expired;

   assign key       = (item_ff.command == CMD_RECEIVE) ? item_ff.seq - 32'd1 : item_ff.seq;
   assign seq_match = valid_ff[idx_ff] && (t_seq[idx_ff] == key);
   assign age       = item_ff.now_ms - t_time[idx_ff];
   assign expired   = valid_ff[idx_ff] && (age > {16'd0, timeout_ff});

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      exp_valid_in = exp_valid_ff;
      exp_seq_in   = exp_seq_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      wr_full      = 1'b0;
      wr_retry     = 1'b0;
      wr_idx       = idx_ff;
      ctrl         = '0;
      new_item     = '0;
      new_item.out_seq       = item_ff.seq;
      new_item.out_type      = item_ff.msg_type;
      new_item.out_position  = item_ff.position;
      new_item.out_payload_a = item_ff.payload_a;
      new_item.out_payload_b = item_ff.payload_b;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               case (req_data.command)
                  CMD_RECEIVE: state_in = (req_data.msg_type == ack_code_ff) ? ST_WALK : ST_RECV;
                  CMD_SEND:    state_in = ST_WALK;
                  CMD_CHECK:   state_in = running_ff ? ST_WALK : ST_FLUSH;
                  default:     state_in = ST_FLUSH;
               endcase
            end
         end
         // delivery of an in-order or first message
         ST_RECV: begin
            if (!exp_valid_ff || exp_seq_ff == item_ff.seq) begin
               exp_valid_in  = 1'b1;
               exp_seq_in    = item_ff.seq + 32'd1;
               new_item.kind = KIND_DELIVER;
               ctrl.push     = 1'b1;
            end
            state_in = ST_ACKS;
         end
         ST_ACKS: begin
            new_item               = '0;
            new_item.kind          = KIND_ACK;
            new_item.out_seq       = exp_seq_ff;
            new_item.out_type      = ack_code_ff;
            ctrl.push              = 1'b1;
            state_in               = ST_FLUSH;
         end
         // one table entry per cycle
         ST_WALK: begin
            state_in = (idx_ff == LAST_IDX) ? ST_FLUSH : ST_WALK;
            idx_in   = idx_ff + IDX_W'(1);
            case (item_ff.command)
               CMD_RECEIVE: begin
                  if (seq_match) begin
                     valid_in[idx_ff] = 1'b0;
                     state_in         = ST_FLUSH;
                  end
               end
               CMD_SEND: begin
                  if (seq_match && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = idx_ff;
                  end
                  if (!valid_ff[idx_ff] && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = idx_ff;
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_in = ST_STORE;
                  end
               end
               default: begin
                  if (expired) begin
                     if (t_retry[idx_ff] >= max_retry_ff) begin
                        valid_in[idx_ff] = 1'b0;
                     end else begin
                        wr_retry               = 1'b1;
                        new_item.kind          = KIND_RETRANSMIT;
                        new_item.out_seq       = t_seq[idx_ff];
                        new_item.out_type      = t_type[idx_ff];
                        new_item.out_position  = t_pos[idx_ff];
                        new_item.out_payload_a = t_pa[idx_ff];
                        new_item.out_payload_b = t_pb[idx_ff];
                        ctrl.push              = 1'b1;
                     end
                  end
               end
            endcase
         end
         // emit the transmit result, then store the sent message or report that the table is full
         ST_STORE: begin
            new_item.kind = KIND_TRANSMIT;
            ctrl.push     = 1'b1;
            if (hit_ff || free_ff) begin
               wr_full          = 1'b1;
               wr_idx           = hit_ff ? hit_idx_ff : free_idx_ff;
               valid_in[wr_idx] = 1'b1;
               state_in         = ST_FLUSH;
            end else begin
               state_in = ST_OVF;
            end
         end
         ST_OVF: begin
            new_item.kind = KIND_OVERFLOW;
            ctrl.push     = 1'b1;
            state_in      = ST_FLUSH;
         end
         ST_FLUSH: begin
            ctrl.flush = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         exp_valid_ff <= 1'b0;
         exp_seq_ff   <= 32'd0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         exp_valid_ff <= exp_valid_in;
         exp_seq_ff   <= exp_seq_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (state_ff == ST_IDLE && start) begin
         item_ff <= req_data;
      end
   end

   // table payload writes
   always_ff @(posedge clock) begin
      if (wr_full) begin
         t_seq[wr_idx]   <= item_ff.seq;
         t_type[wr_idx]  <= item_ff.msg_type;
         t_pos[wr_idx]   <= item_ff.position;
         t_pa[wr_idx]    <= item_ff.payload_a;
         t_pb[wr_idx]    <= item_ff.payload_b;
         t_time[wr_idx]  <= item_ff.now_ms;
         t_retry[wr_idx] <= 8'd0;
      end else if (wr_retry) begin
         t_time[wr_idx]  <= item_ff.now_ms;
         t_retry[wr_idx] <= t_retry[wr_idx] + 8'd1;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   are_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .new_item  (new_item),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

// File: hw/rtl/are_checker.sv
// are_checker: port-level checks of the ack/retransmit engine, bound to the top
// depends on are_pkg
`default_nettype none
module are_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  start,
   input wire                  busy,
   input wire                  rsp_valid,
   input are_pkg::rsp_item_type rsp_data
);
   // an accepted item always occupies the engine
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not follow an accepted item");

   // the final result of an item is never followed directly by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid) else $error("result right after last");

   // idle with nothing started gives no result next cycle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_valid) else $error("result while idle");

   // reset leaves the engine idle and silent
   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid) else $error("not idle after reset");
endmodule

bind ack_retransmit_engine are_checker u_are_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: tb/testbench.sv
// testbench: randomized and directed checking of ack_retransmit_engine
// depends on are_pkg and the engine rtl; predicts every result item in a scoreboard class
`default_nettype none
module testbench;
   import are_pkg::*;

   // expected results and the engine's mirrored state
   class arq_scoreboard;
      rsp_item_type pending_q[$];
      int errors;
      int checked;
      logic [15:0] timeout_ms;
      logic [7:0] retry_limit;
      logic run_en;
      logic [7:0] ack_code;
      logic rx_seen;
      logic [31:0] rx_next;
      logic tbl_valid [TABLE_DEPTH];
      req_item_type tbl_msg [TABLE_DEPTH];
      logic [7:0] tbl_tries [TABLE_DEPTH];

      function new();
         timeout_ms = 16'd500;
         retry_limit = 8'd3;
         run_en = 1'b1;
         ack_code = 8'd0;
         rx_seen = 1'b0;
         rx_next = '0;
         errors = 0;
         checked = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            REG_ACK_TIMEOUT: timeout_ms = val;
            REG_MAX_RETRY: retry_limit = val[7:0];
            REG_RUNNING: run_en = val[0];
            REG_ACK_TYPE: ack_code = val[7:0];
            default: ;
         endcase
      endfunction

      function void push_result(logic [2:0] k, req_item_type m, logic [31:0] sq,
                                ref rsp_item_type outs[$]);
         rsp_item_type r;
         r.kind = k;
         r.out_seq = sq;
         r.out_type = m.msg_type;
         r.out_position = m.position;
         r.out_payload_a = m.payload_a;
         r.out_payload_b = m.payload_b;
         r.last = 1'b0;
         outs.push_back(r);
      endfunction

      // note an accepted item and queue what it should produce
      function void note_item(req_item_type it);
         rsp_item_type outs[$];
         req_item_type ackm;
         int slot;
         slot = -1;
         if (it.command == CMD_RECEIVE) begin
            if (it.msg_type == ack_code) begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (tbl_valid[i] && tbl_msg[i].seq == it.seq - 32'd1) begin
                     tbl_valid[i] = 1'b0;
                     break;
                  end
               end
            end else begin
               if (!rx_seen || rx_next == it.seq) begin
                  rx_next = it.seq + 32'd1;
                  rx_seen = 1'b1;
                  push_result(KIND_DELIVER, it, it.seq, outs);
               end
               ackm = '0;
               ackm.msg_type = ack_code;
               push_result(KIND_ACK, ackm, rx_next, outs);
            end
         end else if (it.command == CMD_SEND) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tbl_valid[i] && tbl_msg[i].seq == it.seq) begin
                  slot = i;
                  break;
               end
            end
            if (slot < 0) begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!tbl_valid[i]) begin
                     slot = i;
                     break;
                  end
               end
            end
            push_result(KIND_TRANSMIT, it, it.seq, outs);
            if (slot >= 0) begin
               tbl_valid[slot] = 1'b1;
               tbl_msg[slot] = it;
               tbl_tries[slot] = 8'd0;
            end else begin
               push_result(KIND_OVERFLOW, it, it.seq, outs);
            end
         end else if (it.command == CMD_CHECK && run_en) begin
            for (int i = 0; i < TABLE_DEPTH && outs.size() < 16; i++) begin
               if (tbl_valid[i] && (it.now_ms - tbl_msg[i].now_ms) > {16'd0, timeout_ms})
               begin
                  if (tbl_tries[i] >= retry_limit) begin
                     tbl_valid[i] = 1'b0;
                  end else begin
                     push_result(KIND_RETRANSMIT, tbl_msg[i], tbl_msg[i].seq, outs);
                     tbl_tries[i] = tbl_tries[i] + 8'd1;
                     tbl_msg[i].now_ms = it.now_ms;
                  end
               end
            end
         end
         if (outs.size() > 0) begin
            outs[outs.size() - 1].last = 1'b1;
         end
         foreach (outs[i]) pending_q.push_back(outs[i]);
      endfunction

      // compare one result item with the oldest expectation
      function void check_result(rsp_item_type got);
         rsp_item_type exp_r;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %p", $time, got);
            return;
         end
         exp_r = pending_q.pop_front();
         checked++;
         if (got !== exp_r) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_item_type req_data;
   logic rsp_valid;
   rsp_item_type rsp_data;
   logic csr_we;
   logic [1:0] csr_addr;
   logic [15:0] csr_wdata;
   arq_scoreboard arq_sb;
   int sent_items;
   logic [31:0] clock_ms;
   logic [31:0] tx_seq;

   ack_retransmit_engine DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         arq_sb.check_result(rsp_data);
      end
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // present one item, keep start high until busy drops, then note the item in the scoreboard
   task automatic issue_item(req_item_type it);
      start <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      arq_sb.note_item(it);
      sent_items++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic idle_burst();
      repeat ($urandom_range(1, 17)) @(posedge clock);
   endtask

   // wait until every expected result is out, then let the engine settle
   task automatic drain();
      while (arq_sb.pending_q.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      arq_sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_item_type make_item(logic [1:0] cmd, logic [31:0] sq,
                                              logic [7:0] ty, logic [31:0] now);
      req_item_type it;
      it.command = cmd;
      it.seq = sq;
      it.msg_type = ty;
      it.position = $urandom;
      it.payload_a = $urandom;
      it.payload_b = $urandom;
      it.now_ms = now;
      return it;
   endfunction

   // random mix of send, ack, receive, check and unused items
   task automatic random_phase(int count, bit with_gaps);
      req_item_type it;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         clock_ms = clock_ms + $urandom_range(0, 400);
         if (pick < 35) begin
            tx_seq = ($urandom_range(0, 3) == 0) ? $urandom : tx_seq + 32'd1;
            it = make_item(CMD_SEND, tx_seq, 8'($urandom), clock_ms);
         end else if (pick < 50) begin
            it = make_item(CMD_RECEIVE, tx_seq - $urandom_range(0, 20) + 32'd1,
                           arq_sb.ack_code, clock_ms);
         end else if (pick < 75) begin
            it = make_item(CMD_RECEIVE,
                           ($urandom_range(0, 3) != 0) ? arq_sb.rx_next : $urandom,
                           8'($urandom), clock_ms);
         end else if (pick < 95) begin
            it = make_item(CMD_CHECK, $urandom, 8'($urandom),
                           ($urandom_range(0, 9) == 0) ? $urandom : clock_ms);
         end else begin
            it = make_item(CMD_UNUSED, $urandom, 8'($urandom), $urandom);
         end
         issue_item(it);
         if (with_gaps && $urandom_range(0, 3) == 0) idle_burst();
      end
   endtask

   initial begin
      req_item_type it;
      arq_sb = new();
      sent_items = 0;
      clock_ms = 32'd1000;
      tx_seq = 32'd100;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_addr <= REG_ACK_TIMEOUT;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wrap of received sequence, duplicates, ack of wrapped seq
      issue_item(make_item(CMD_RECEIVE, 32'hFFFF_FFFF, 8'hFF, 32'd0));
      issue_item(make_item(CMD_RECEIVE, 32'h0, 8'h01, 32'd0));
      issue_item(make_item(CMD_RECEIVE, 32'h5, 8'h80, 32'd0));
      issue_item(make_item(CMD_SEND, 32'hFFFF_FFFF, 8'hFF, 32'd0));
      issue_item(make_item(CMD_SEND, 32'hFFFF_FFFF, 8'h00, 32'd10));
      issue_item(make_item(CMD_RECEIVE, 32'h0, 8'h00, 32'd0));
      issue_item(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      // fill the table past full
      for (int i = 0; i < 18; i++) begin
         it = make_item(CMD_SEND, 32'd200 + i, i[7:0], 32'hFFFF_FF00);
         if (i == 0) begin
            it.position = 32'h8000_0000;
            it.payload_a = 32'h7FFF_FFFF;
            it.payload_b = 32'hFFFF_FFFF;
         end
         issue_item(it);
      end
      // wrapped age: every entry expires, sixteen retransmissions
      issue_item(make_item(CMD_CHECK, 32'd0, 8'd0, 32'd1000));
      drain();

      // stopped engine, then extreme settings
      write_csr(REG_RUNNING, 16'd0);
      issue_item(make_item(CMD_CHECK, 32'd0, 8'd0, 32'd90000));
      drain();
      write_csr(REG_RUNNING, 16'd1);
      write_csr(REG_MAX_RETRY, 16'd0);
      write_csr(REG_ACK_TIMEOUT, 16'hFFFF);
      issue_item(make_item(CMD_CHECK, 32'd0, 8'd0, 32'd1000 + 32'd65535));
      issue_item(make_item(CMD_CHECK, 32'd0, 8'd0, 32'd1000 + 32'd65536));
      drain();

      // random phases over several settings
      write_csr(REG_MAX_RETRY, 16'd255);
      write_csr(REG_ACK_TIMEOUT, 16'd0);
      write_csr(REG_ACK_TYPE, 16'd255);
      random_phase(120, 1'b1);
      drain();
      write_csr(REG_MAX_RETRY, 16'd2);
      write_csr(REG_ACK_TIMEOUT, 16'd300);
      write_csr(REG_ACK_TYPE, 16'd7);
      random_phase(120, 1'b1);
      drain();
      write_csr(REG_MAX_RETRY, 16'd3);
      write_csr(REG_ACK_TIMEOUT, 16'd500);
      write_csr(REG_ACK_TYPE, 16'd0);
      random_phase(110, 1'b1);
      drain();
      random_phase(100, 1'b0);

      while (arq_sb.pending_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("run covered %0d items and %0d checked result items", sent_items,
               arq_sb.checked);
      $display("including table overflow, wrapped ages, retry drops and stopped checks");
      if (arq_sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
